// File: hw/rtl/irzl_pkg.sv
// Shared types and constants for the IPv4 range zone lookup block.
`default_nettype none
package irzl_pkg;
  localparam int MAX_BUCKETS = 256;
  localparam int ENTRY_DEPTH = 16384;
  localparam int BKT_AW = 8;
  localparam int ENT_AW = 14;
  localparam int HC_W = 9;
  localparam int BASE_W = 25;
  localparam int QDEPTH = 2;

  localparam logic [1:0] OP_LOAD_BUCKET = 2'd0;
  localparam logic [1:0] OP_LOAD_ENTRY  = 2'd1;
  localparam logic [1:0] OP_LOOKUP      = 2'd2;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_PRIVATE   = 2'd2;

  typedef enum logic [1:0] {
    CMD_BUCKET,
    CMD_ENTRY,
    CMD_LOOKUP,
    CMD_PRIVATE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [13:0] slot;
    logic [7:0]  hi_byte;
    logic [15:0] size;
    logic [23:0] key;
    logic [7:0]  zone;
    logic [31:0] address;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BWAIT,
    S_BCHK,
    S_EWAIT,
    S_ECHK,
    S_DONE
  } eng_state_t;

  function automatic logic is_private(input logic [31:0] a);
    logic [7:0] o0;
    logic [7:0] o1;
    o0 = a[31:24];
    o1 = a[23:16];
    return (o0 == 8'd10) || (o0 == 8'd172 && o1 > 8'd15 && o1 < 8'd32) ||
           (o0 == 8'd192 && o1 == 8'd168);
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/irzl_in_if.sv
// Input channel interface.
`default_nettype none
interface irzl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [13:0] slot;
  logic [7:0]  bucket_high_byte;
  logic [15:0] bucket_size;
  logic [23:0] entry_low_bits;
  logic signed [7:0] entry_zone;
  logic [31:0] address;
  modport source (output valid, opcode, slot, bucket_high_byte, bucket_size,
                  entry_low_bits, entry_zone, address, input ready);
  modport sink (input valid, opcode, slot, bucket_high_byte, bucket_size,
                entry_low_bits, entry_zone, address, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/irzl_out_if.sv
// Result channel interface.
`default_nettype none
interface irzl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic signed [7:0] zone;
  modport source (output valid, status, zone, input ready);
  modport sink (input valid, status, zone, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/irzl_ram.sv
// Generic single-port-write, one-read RAM with registered read.
`default_nettype none
module irzl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/irzl_front.sv
// Front end: accepts transactions, classifies them, queues commands.
`default_nettype none
module irzl_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  irzl_in_if.sink            in_ch,
  output logic               cmd_valid,
  output irzl_pkg::cmd_t     cmd,
  input  wire logic          cmd_pop
);
  irzl_pkg::cmd_t q_r [irzl_pkg::QDEPTH];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  irzl_pkg::cmd_t c;
  logic push, drop;

  always_comb begin
    c.slot    = in_ch.slot;
    c.hi_byte = in_ch.bucket_high_byte;
    c.size    = in_ch.bucket_size;
    c.key     = in_ch.entry_low_bits;
    c.zone    = in_ch.entry_zone;
    c.address = in_ch.address;
    drop = 1'b0;
    unique case (in_ch.opcode)
      irzl_pkg::OP_LOAD_BUCKET: c.kind = irzl_pkg::CMD_BUCKET;
      irzl_pkg::OP_LOAD_ENTRY:  c.kind = irzl_pkg::CMD_ENTRY;
      irzl_pkg::OP_LOOKUP:
        c.kind = irzl_pkg::is_private(in_ch.address) ? irzl_pkg::CMD_PRIVATE
                                                      : irzl_pkg::CMD_LOOKUP;
      default: begin
        c.kind = irzl_pkg::CMD_ENTRY;
        drop = 1'b1;
      end
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'(irzl_pkg::QDEPTH));
  assign push = in_ch.valid && in_ch.ready && !drop;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (cmd_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'(irzl_pkg::QDEPTH) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !cmd_pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(irzl_pkg::QDEPTH)) else $error("queue count out of range");
endmodule
`default_nettype wire

// File: hw/rtl/irzl_engine.sv
// Back end: table loads and the bucket walk / entry scan of lookups.
`default_nettype none
module irzl_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [irzl_pkg::HC_W-1:0]   header_count,
  input  wire logic                        cmd_valid,
  input  irzl_pkg::cmd_t                   cmd,
  output logic                             cmd_pop,
  irzl_out_if.source                       out_ch
);
  irzl_pkg::eng_state_t st_r, st_nxt;
  irzl_pkg::cmd_t cur_r;
  logic [irzl_pkg::HC_W-1:0]   bi_r, bi_nxt, n_lim;
  logic [irzl_pkg::BASE_W-1:0] base_r, base_nxt, idx_r, idx_nxt, end_r, end_nxt;
  logic [7:0] zone_r, zone_nxt;
  logic found_r, found_nxt;
  logic ov_r, ov_nxt;
  logic [1:0] ost_r, ost_nxt;
  logic [7:0] ozone_r, ozone_nxt;

  logic b_we, e_we;
  logic [irzl_pkg::BKT_AW-1:0] b_raddr;
  logic [irzl_pkg::ENT_AW-1:0] e_raddr;
  logic [23:0] b_rdata;
  logic [31:0] e_rdata;

  assign n_lim = (header_count > irzl_pkg::HC_W'(irzl_pkg::MAX_BUCKETS)) ?
                 irzl_pkg::HC_W'(irzl_pkg::MAX_BUCKETS) : header_count;
  assign b_we = (st_r == irzl_pkg::S_IDLE) && cmd_valid && cmd.kind == irzl_pkg::CMD_BUCKET;
  assign e_we = (st_r == irzl_pkg::S_IDLE) && cmd_valid && cmd.kind == irzl_pkg::CMD_ENTRY &&
                {1'b0, cmd.slot} < 15'(irzl_pkg::ENTRY_DEPTH);
  assign b_raddr = bi_r[irzl_pkg::BKT_AW-1:0];
  assign e_raddr = idx_r[irzl_pkg::ENT_AW-1:0];

  irzl_ram #(.WIDTH(24), .DEPTH(irzl_pkg::MAX_BUCKETS)) u_bkt (
    .clk(clk), .we(b_we), .waddr(cmd.slot[irzl_pkg::BKT_AW-1:0]),
    .wdata({cmd.hi_byte, cmd.size}), .raddr(b_raddr), .rdata(b_rdata));
  irzl_ram #(.WIDTH(32), .DEPTH(irzl_pkg::ENTRY_DEPTH)) u_ent (
    .clk(clk), .we(e_we), .waddr(cmd.slot[irzl_pkg::ENT_AW-1:0]),
    .wdata({cmd.key, cmd.zone}), .raddr(e_raddr), .rdata(e_rdata));

  // next state
  always_comb begin
    st_nxt = st_r;
    bi_nxt = bi_r; base_nxt = base_r; idx_nxt = idx_r; end_nxt = end_r;
    zone_nxt = zone_r; found_nxt = found_r; ov_nxt = ov_r;
    ost_nxt = ost_r; ozone_nxt = ozone_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      irzl_pkg::S_IDLE: begin
        if (cmd_valid) begin
          bi_nxt = '0; base_nxt = '0; found_nxt = 1'b0; zone_nxt = '0;
          unique case (cmd.kind)
            irzl_pkg::CMD_LOOKUP:
              st_nxt = (n_lim == '0) ? irzl_pkg::S_DONE : irzl_pkg::S_BWAIT;
            irzl_pkg::CMD_PRIVATE: st_nxt = irzl_pkg::S_DONE;
            default: st_nxt = irzl_pkg::S_IDLE;
          endcase
        end
      end
      irzl_pkg::S_BWAIT: st_nxt = irzl_pkg::S_BCHK;
      irzl_pkg::S_BCHK: begin
        if (b_rdata[23:16] == cur_r.address[31:24]) begin
          idx_nxt = base_r;
          end_nxt = base_r + irzl_pkg::BASE_W'(b_rdata[15:0]);
          st_nxt = (b_rdata[15:0] == '0) ? irzl_pkg::S_DONE : irzl_pkg::S_EWAIT;
        end else begin
          base_nxt = base_r + irzl_pkg::BASE_W'(b_rdata[15:0]);
          bi_nxt = bi_r + 1'b1;
          st_nxt = (bi_r + 1'b1 >= n_lim) ? irzl_pkg::S_DONE : irzl_pkg::S_BWAIT;
        end
      end
      irzl_pkg::S_EWAIT: begin
        st_nxt = (idx_r >= irzl_pkg::BASE_W'(irzl_pkg::ENTRY_DEPTH)) ?
                 irzl_pkg::S_DONE : irzl_pkg::S_ECHK;
      end
      irzl_pkg::S_ECHK: begin
        if (e_rdata[31:8] > cur_r.address[23:0]) begin
          st_nxt = irzl_pkg::S_DONE;
        end else begin
          zone_nxt = e_rdata[7:0];
          found_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
          st_nxt = (idx_r + 1'b1 >= end_r) ? irzl_pkg::S_DONE : irzl_pkg::S_EWAIT;
        end
      end
      irzl_pkg::S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          st_nxt = irzl_pkg::S_IDLE;
          if (cur_r.kind == irzl_pkg::CMD_PRIVATE) begin
            ost_nxt = irzl_pkg::ST_PRIVATE; ozone_nxt = '0;
          end else if (found_r) begin
            ost_nxt = irzl_pkg::ST_FOUND; ozone_nxt = zone_r;
          end else begin
            ost_nxt = irzl_pkg::ST_NOT_FOUND; ozone_nxt = '0;
          end
        end
      end
      default: st_nxt = irzl_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop = (st_r == irzl_pkg::S_IDLE) && cmd_valid;
    out_ch.valid = ov_r;
    out_ch.status = ost_r;
    out_ch.zone = ozone_r;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur_r <= cmd;
    bi_r <= bi_nxt; base_r <= base_nxt; idx_r <= idx_nxt; end_r <= end_nxt;
    zone_r <= zone_nxt; found_r <= found_nxt;
    ost_r <= ost_nxt; ozone_r <= ozone_nxt;
    if (!rst_n) begin
      st_r <= irzl_pkg::S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_zero_zone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != irzl_pkg::ST_FOUND |-> out_ch.zone == '0)
    else $error("zone nonzero");
  a_bi_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == irzl_pkg::S_BCHK |-> bi_r < n_lim) else $error("bucket walk past count");
endmodule
`default_nettype wire

// File: hw/rtl/ipv4_range_zone_lookup_core.sv
// Top level of the IPv4 range zone lookup block.
// A front end takes load and lookup transactions, screens private addresses
// (10/8, 172.16/12, 192.168/16) and queues commands in a two-entry queue; the
// back end writes the bucket RAM and entry RAM or runs a lookup. A lookup
// reads one bucket at a time (S_BWAIT, S_BCHK) until the high byte matches,
// then one entry at a time (S_EWAIT, S_ECHK) through that bucket, since each
// RAM has a single registered read port. Loads are written from idle, and
// private addresses go straight to the result. Results sit in an output
// register so the next command starts while a result waits. The user must
// write header_count via cfg_we only while idle; the block itself does not
// enforce this.
`default_nettype none
module ipv4_range_zone_lookup_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  irzl_in_if.sink         in_ch,
  irzl_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata
);
  logic [irzl_pkg::HC_W-1:0] hc_r;
  logic cmd_valid, cmd_pop;
  irzl_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) hc_r <= '0;
    else if (cfg_we) hc_r <= cfg_wdata;
  end

  irzl_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));
  irzl_engine u_eng (.clk(clk), .rst_n(rst_n), .header_count(hc_r),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .out_ch(out_ch));
endmodule
`default_nettype wire

// File: verif/tb_irzl_types.sv
// Testbench-side types for the IPv4 range zone lookup bench.
`timescale 1ns / 1ps
package tb_irzl_types;
  typedef struct {
    logic [1:0]  opcode;
    logic [13:0] slot;
    logic [7:0]  hi_byte;
    logic [15:0] size;
    logic [23:0] key;
    logic [7:0]  zone;
    logic [31:0] address;
  } txn_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] zone;
  } zone_result_t;
endpackage

// File: verif/tb_ipv4_range_zone_lookup_core.sv
// Bench for ipv4_range_zone_lookup_core: table loads, lookups, scoreboard.
`timescale 1ns / 1ps
module tb_ipv4_range_zone_lookup_core;
  import irzl_pkg::*;
  import tb_irzl_types::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;

  irzl_in_if in_ch ();
  irzl_out_if out_ch ();

  ipv4_range_zone_lookup_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow of the lookup tables and the bucket count register.
  logic [23:0] bucket_shadow [MAX_BUCKETS];
  logic [31:0] entry_shadow [ENTRY_DEPTH];
  logic [8:0]  hc_shadow;

  txn_t pending_txns[$];
  zone_result_t expected_zones[$];
  int  fail_count = 0;
  int  cycles = 0;
  bit  hold_out = 0;        // long receiver hold-off request
  bit  in_acc = 0;          // input transaction taken at the last rising edge
  bit  out_acc = 0;         // result taken at the last rising edge

  // Predictor: apply a transaction to the shadow state; lookups push a result.
  task automatic predict(input txn_t t);
    zone_result_t r;
    int n, base, cnt, idx;
    bit have, found;
    logic [7:0] z;
    base = 0; cnt = 0; have = 0; found = 0; z = '0;
    case (t.opcode)
      OP_LOAD_BUCKET: bucket_shadow[t.slot[7:0]] = {t.hi_byte, t.size};
      OP_LOAD_ENTRY: entry_shadow[t.slot] = {t.key, t.zone};
      OP_LOOKUP: begin
        if ((t.address[31:24] == 8'd10) ||
            (t.address[31:24] == 8'd172 && t.address[23:16] > 8'd15 &&
             t.address[23:16] < 8'd32) ||
            (t.address[31:24] == 8'd192 && t.address[23:16] == 8'd168)) begin
          r.status = ST_PRIVATE;
          r.zone = '0;
        end else begin
          n = (hc_shadow > MAX_BUCKETS) ? MAX_BUCKETS : hc_shadow;
          for (int i = 0; i < n && !have; i++) begin
            if (bucket_shadow[i][23:16] == t.address[31:24]) begin
              cnt = bucket_shadow[i][15:0];
              have = 1;
            end else begin
              base += bucket_shadow[i][15:0];
            end
          end
          if (have) begin
            for (int i = 0; i < cnt; i++) begin
              idx = base + i;
              if (idx >= ENTRY_DEPTH) break;
              if (entry_shadow[idx][31:8] > t.address[23:0]) break;
              z = entry_shadow[idx][7:0];
              found = 1;
            end
          end
          r.status = found ? ST_FOUND : ST_NOT_FOUND;
          r.zone = found ? z : 8'd0;
        end
        expected_zones.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Driver: one transaction at a time, random gap after each.
  int gap = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0; in_ch.slot = '0; in_ch.bucket_high_byte = '0;
    in_ch.bucket_size = '0; in_ch.entry_low_bits = '0; in_ch.entry_zone = '0;
    in_ch.address = '0;
  end

  always @(negedge clk) begin
    txn_t t;
    if (rst_n) begin
      // a waiting transaction holds until it is taken
      if (!in_ch.valid || in_acc) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_txns.size() > 0) begin
          t = pending_txns.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= t.opcode;
          in_ch.slot <= t.slot;
          in_ch.bucket_high_byte <= t.hi_byte;
          in_ch.bucket_size <= t.size;
          in_ch.entry_low_bits <= t.key;
          in_ch.entry_zone <= t.zone;
          in_ch.address <= t.address;
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Predict on acceptance so the scoreboard tracks the block's view.
  always @(posedge clk) begin
    txn_t t;
    in_acc = rst_n && in_ch.valid && in_ch.ready;
    if (in_acc) begin
      t.opcode = in_ch.opcode; t.slot = in_ch.slot;
      t.hi_byte = in_ch.bucket_high_byte; t.size = in_ch.bucket_size;
      t.key = in_ch.entry_low_bits; t.zone = in_ch.entry_zone;
      t.address = in_ch.address;
      predict(t);
    end
  end

  // Receiver stall: random per-result wait, or a long counted hold-off.
  int stall = 0;
  int hold_cnt = 0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_out) begin
      hold_out <= 1'b0;
      hold_cnt <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (out_acc) begin
      out_ch.ready <= 1'b0;
      stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor / scoreboard.
  always @(posedge clk) begin
    zone_result_t e;
    out_acc = rst_n && out_ch.valid && out_ch.ready;
    if (out_acc) begin
      if (expected_zones.size() == 0) begin
        $error("unexpected result status=%0d zone=%0d", out_ch.status, out_ch.zone);
        fail_count++;
      end else begin
        e = expected_zones.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.zone !== e.zone) begin
          $error("zone: expected %0d, actual %0d", $signed(e.zone), out_ch.zone);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  function automatic txn_t mk(input logic [1:0] op);
    txn_t t;
    t.opcode = op;
    t.slot = 14'($urandom()); t.hi_byte = 8'($urandom()); t.size = 16'($urandom());
    t.key = 24'($urandom()); t.zone = 8'($urandom()); t.address = $urandom();
    return t;
  endfunction

  task automatic push_lookup(input logic [31:0] a);
    txn_t t;
    t = mk(OP_LOOKUP);
    t.address = a;
    pending_txns.push_back(t);
  endtask

  // Block drained: queue empty, input idle, nothing expected, then a tail
  // of cycles for loads still in flight.
  task automatic drain();
    while (pending_txns.size() > 0 || in_ch.valid || expected_zones.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_hc(input logic [8:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    hc_shadow = v;
  endtask

  // Fill nb buckets (distinct or duplicate bytes) and all their entries,
  // packed from entry 0, with ascending keys. Sizes stay small.
  int tbl_nb;
  logic [7:0] tbl_bytes [MAX_BUCKETS];
  task automatic load_table(input int nb, input int max_size, input bit dups);
    txn_t t;
    int base, sz;
    logic [23:0] k;
    base = 0;
    tbl_nb = nb;
    for (int b = 0; b < nb; b++) begin
      t = mk(OP_LOAD_BUCKET);
      t.slot = {6'($urandom_range(0, 63)), b[7:0]};
      sz = $urandom_range(0, max_size);
      if (base + sz > ENTRY_DEPTH) sz = 0;
      t.size = 16'(sz);
      t.hi_byte = (dups && b > 0 && $urandom_range(0, 3) == 0) ? tbl_bytes[b - 1]
                                                               : 8'($urandom());
      tbl_bytes[b] = t.hi_byte;
      pending_txns.push_back(t);
      k = 24'($urandom_range(0, 1 << 20));
      for (int i = 0; i < sz; i++) begin
        t = mk(OP_LOAD_ENTRY);
        t.slot = 14'(base + i);
        t.key = k;
        pending_txns.push_back(t);
        k = k + 24'($urandom_range(1, 1 << 21));
        if (k < t.key) k = 24'hffffff;
      end
      base += sz;
    end
  endtask

  // Lookup only addresses whose first matching bucket is fully written; the
  // byte either matches a loaded bucket or none at all (needs full walk of
  // written buckets only, which holds since hc <= loaded buckets).
  task automatic random_lookup();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(0, 3) != 0 && tbl_nb > 0)
      a[31:24] = tbl_bytes[$urandom_range(0, tbl_nb - 1)];
    case ($urandom_range(0, 9))
      0: a[31:24] = 8'd10;
      1: begin a[31:24] = 8'd172; a[23:16] = 8'($urandom_range(14, 33)); end
      2: begin a[31:24] = 8'd192; a[23:16] = 8'($urandom_range(167, 169)); end
      default: ;
    endcase
    push_lookup(a);
  endtask

  initial begin
    txn_t t;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero buckets, private edges, unused opcode.
    hc_shadow = '0;
    write_hc(9'd0);
    push_lookup(32'h0A00_0000); push_lookup(32'hAC10_0000);
    push_lookup(32'hAC1F_FFFF); push_lookup(32'hAC0F_FFFF);
    push_lookup(32'hAC20_0000); push_lookup(32'hC0A8_1234);
    push_lookup(32'hC0A9_0000); push_lookup(32'hFFFF_FFFF);
    push_lookup(32'h0000_0000);
    pending_txns.push_back(mk(OP_UNUSED));
    // Slots beyond the table wrap on the low 8 bits; extreme entry fields.
    t = mk(OP_LOAD_BUCKET); t.slot = 14'h3F00; t.hi_byte = 8'hFF; t.size = 16'd2;
    pending_txns.push_back(t);
    t = mk(OP_LOAD_BUCKET); t.slot = 14'h0001; t.hi_byte = 8'h00; t.size = 16'hFFFF;
    pending_txns.push_back(t);
    t = mk(OP_LOAD_ENTRY); t.slot = 0; t.key = 24'h0; t.zone = 8'h80;
    pending_txns.push_back(t);
    t = mk(OP_LOAD_ENTRY); t.slot = 1; t.key = 24'hFFFFFF; t.zone = 8'h7F;
    pending_txns.push_back(t);
    drain();
    write_hc(9'd1);
    push_lookup(32'hFF00_0000); push_lookup(32'hFFFF_FFFF);
    push_lookup(32'h0100_0000);
    drain();
    write_hc(9'd511);  // clamps, but unwritten buckets must not be walked
    write_hc(9'd1);
    drain();

    // Random phases with several header counts.
    for (int ph = 0; ph < 8; ph++) begin
      int nb, hc;
      nb = (ph == 7) ? MAX_BUCKETS : $urandom_range(1, 24);
      load_table(nb, (ph == 7) ? 1 : 8, ph % 2 == 1);
      // An entry at the deep end of the store too.
      if (ph == 3) begin
        t = mk(OP_LOAD_ENTRY); t.slot = 14'h3FFF; pending_txns.push_back(t);
      end
      drain();
      case (ph)
        0: hc = 0;
        7: hc = (MAX_BUCKETS);
        default: hc = $urandom_range(1, nb);
      endcase
      write_hc(hc[8:0]);
      if (ph == 7) tbl_nb = MAX_BUCKETS;
      else tbl_nb = hc;
      // Addresses whose byte is missing walk exactly hc written buckets.
      for (int i = 0; i < 40; i++) begin
        if (ph == 2 && i == 20) begin
          // long receiver hold-off while the sender keeps going
          for (int j = 0; j < 8; j++) random_lookup();
          hold_out = 1;
        end
        if (ph == 4 && i == 35) drain();
        random_lookup();
        if (ph == 2 && i < 30) while (pending_txns.size() > 4) @(posedge clk);
      end
      drain();
    end
    write_hc(9'd256);
    drain();
    repeat (600) @(posedge clk);
    if (fail_count == 0 && expected_zones.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
